// File: sv/mcct_pkg.sv
// ----------------------------------------------------------------------------
// mcct_pkg: shared constants for the moving circles collision time unit
// Default widths, register reset value and output time format.
// ----------------------------------------------------------------------------
package mcct_pkg;

	localparam int COORD_WIDTH_DEF    = 21;
	localparam int TIME_FRAC_BITS_DEF = 16;
	localparam int RADIUS_WIDTH       = 16;
	localparam int TIME_WIDTH         = 32;
	// quotient bits kept by the divider: time range plus one overflow bit
	localparam int QUOT_BITS          = TIME_WIDTH + 1;

	localparam logic [RADIUS_WIDTH-1:0] EVENT_RADIUS_RESET = 16'd512;

endpackage

// File: sv/moving_circles_collision_time_unit.sv
// ----------------------------------------------------------------------------
// moving_circles_collision_time_unit: when do two moving circles meet
// Fixed-point solve of |d + t*dv|^2 = r^2, one pair per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): positions and velocities of two
//    circles, 8 fraction bits. One transfer per cycle unless the output stalls.
//  - Output channel (out_valid/out_ready): hit flag and hit_time, signed with
//    TIME_FRAC_BITS fraction bits, saturated to 32 bits, 0 when no hit.
//  - cfg_we/cfg_wdata write event_radius (8 fraction bits); write only while
//    the pipe is empty.
//  - SW is the width of the square root (ceil of half the discriminant
//    magnitude width). Throughput is one item per cycle unless the output
//    stalls.
//  - The square root (one root bit per stage) and the divider (one quotient
//    bit per stage, 33 stages) set the depth.
//  - A receiver stall freezes the whole pipe; in_ready drops only while a
//    result waits at the output and out_ready is low. Nothing is dropped.
//  - Reset clears all valid bits and loads event_radius with two ship radii.
// ----------------------------------------------------------------------------
module moving_circles_collision_time_unit #(
	parameter int COORD_WIDTH    = mcct_pkg::COORD_WIDTH_DEF,
	parameter int TIME_FRAC_BITS = mcct_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mcct_pkg::RADIUS_WIDTH-1:0]     cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_WIDTH-1:0]         first_x,
	input  logic signed [COORD_WIDTH-1:0]         first_y,
	input  logic signed [COORD_WIDTH-1:0]         second_x,
	input  logic signed [COORD_WIDTH-1:0]         second_y,
	input  logic signed [COORD_WIDTH-1:0]         first_vx,
	input  logic signed [COORD_WIDTH-1:0]         first_vy,
	input  logic signed [COORD_WIDTH-1:0]         second_vx,
	input  logic signed [COORD_WIDTH-1:0]         second_vy,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  hit,
	output logic signed [mcct_pkg::TIME_WIDTH-1:0] hit_time
);

	localparam int TW_OUT = mcct_pkg::TIME_WIDTH;
	localparam int QB     = mcct_pkg::QUOT_BITS;
	localparam int RW     = mcct_pkg::RADIUS_WIDTH;
	localparam int DW     = COORD_WIDTH + 1;          // signed differences
	localparam int P      = 2 * DW;                   // product of magnitudes
	localparam int AMW    = P + 1;                    // A, unsigned
	localparam int HSW    = P + 2;                    // H, signed
	localparam int HMW    = HSW - 1;
	localparam int CSW    = ((P + 1) > 2 * RW ? (P + 1) : 2 * RW) + 2;
	localparam int CMW    = CSW - 1;
	localparam int DSW    = ((2 * HMW) > (AMW + CMW) ? (2 * HMW) : (AMW + CMW)) + 2;
	localparam int DMW    = DSW - 1;
	localparam int SW     = (DMW + 1) / 2;            // root bits
	localparam int DUW    = 2 * SW;                   // root datapath width
	localparam int TW     = (HSW > SW + 1 ? HSW : SW + 1) + 2;  // root numerator
	localparam int NW     = TW + TIME_FRAC_BITS;      // shifted numerator
	localparam int NST    = SW + QB + 11;             // pipeline depth

	logic            en;
	logic [NST-1:0]  vld_q;
	logic [RW-1:0]   radius_q;

	// advance the whole pipe unless a result is held at the output
	assign en        = !vld_q[NST-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			radius_q <= mcct_pkg::EVENT_RADIUS_RESET;
		end else begin
			if (en) begin
				vld_q <= {vld_q[NST-2:0], in_valid};
			end
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
		end
	end

	// ---------------- stage 1: differences as sign and magnitude ----------------
	logic signed [DW-1:0] dx_c, dy_c, dvx_c, dvy_c;
	logic [DW-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic          dxn_s1, dyn_s1, dvxn_s1, dvyn_s1;

	assign dx_c  = DW'(first_x) - DW'(second_x);
	assign dy_c  = DW'(first_y) - DW'(second_y);
	assign dvx_c = DW'(first_vx) - DW'(second_vx);
	assign dvy_c = DW'(first_vy) - DW'(second_vy);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
			dy_s1   <= dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
			dvx_s1  <= dvx_c[DW-1] ? DW'(-dvx_c) : DW'(dvx_c);
			dvy_s1  <= dvy_c[DW-1] ? DW'(-dvy_c) : DW'(dvy_c);
			dxn_s1  <= dx_c[DW-1];
			dyn_s1  <= dy_c[DW-1];
			dvxn_s1 <= dvx_c[DW-1];
			dvyn_s1 <= dvy_c[DW-1];
		end
	end

	// ---------------- stage 2: squares and cross products ----------------
	logic [P-1:0]    aa_s2, bb_s2, xv_s2, yv_s2, xx_s2, yy_s2;
	logic            xvn_s2, yvn_s2;
	logic [2*RW-1:0] rr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s2  <= dvx_s1 * dvx_s1;
			bb_s2  <= dvy_s1 * dvy_s1;
			xv_s2  <= dx_s1 * dvx_s1;
			yv_s2  <= dy_s1 * dvy_s1;
			xx_s2  <= dx_s1 * dx_s1;
			yy_s2  <= dy_s1 * dy_s1;
			xvn_s2 <= dxn_s1 ^ dvxn_s1;
			yvn_s2 <= dyn_s1 ^ dvyn_s1;
			rr_s2  <= radius_q * radius_q;
		end
	end

	// ---------------- stage 3: A, H, C ----------------
	logic signed [HSW-1:0] xv_c, yv_c;
	logic [AMW-1:0]        a_s3;
	logic signed [HSW-1:0] h_s3;
	logic signed [CSW-1:0] c_s3;

	assign xv_c = xvn_s2 ? -$signed(HSW'(xv_s2)) : $signed(HSW'(xv_s2));
	assign yv_c = yvn_s2 ? -$signed(HSW'(yv_s2)) : $signed(HSW'(yv_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= AMW'(aa_s2) + AMW'(bb_s2);
			h_s3 <= xv_c + yv_c;
			c_s3 <= $signed(CSW'(xx_s2) + CSW'(yy_s2) - CSW'(rr_s2));
		end
	end

	// ---------------- stage 4: magnitudes for the wide products ----------------
	logic [AMW-1:0]        a_s4;
	logic signed [HSW-1:0] h_s4;
	logic [HMW-1:0]        hm_s4;
	logic [CMW-1:0]        cm_s4;
	logic                  cn_s4, az_s4, cle_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4   <= a_s3;
			h_s4   <= h_s3;
			hm_s4  <= h_s3[HSW-1] ? HMW'(-h_s3) : HMW'(h_s3);
			cm_s4  <= c_s3[CSW-1] ? CMW'(-c_s3) : CMW'(c_s3);
			cn_s4  <= c_s3[CSW-1];
			az_s4  <= (a_s3 == '0);
			cle_s4 <= c_s3[CSW-1] || (c_s3 == '0);
		end
	end

	// ---------------- stages 5-6: H^2 and A*|C| ----------------
	logic [2*HMW-1:0]     hh_s6;
	logic [AMW+CMW-1:0]   ac_s6;
	logic [AMW-1:0]        a_s5, a_s6;
	logic signed [HSW-1:0] h_s5, h_s6;
	logic                  cn_s5, cn_s6, az_s5, az_s6, cle_s5, cle_s6;

	mcct_mul #(.AW(HMW), .BW(HMW)) u_mul_hh (
		.clk (clk), .en (en), .a (hm_s4), .b (hm_s4), .p (hh_s6)
	);

	mcct_mul #(.AW(AMW), .BW(CMW)) u_mul_ac (
		.clk (clk), .en (en), .a (a_s4), .b (cm_s4), .p (ac_s6)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5   <= a_s4;
			h_s5   <= h_s4;
			cn_s5  <= cn_s4;
			az_s5  <= az_s4;
			cle_s5 <= cle_s4;
			a_s6   <= a_s5;
			h_s6   <= h_s5;
			cn_s6  <= cn_s5;
			az_s6  <= az_s5;
			cle_s6 <= cle_s5;
		end
	end

	// ---------------- stage 7: discriminant, then the root pipe ----------------
	logic signed [DSW-1:0] d_c;
	logic                  dneg_c;

	logic [DUW-1:0]        sq_x_s   [0:SW];
	logic [DUW-1:0]        sq_r_s   [0:SW];
	logic signed [HSW-1:0] sq_h_s   [0:SW];
	logic [AMW-1:0]        sq_a_s   [0:SW];
	logic                  sq_hit_s [0:SW];
	logic                  sq_tz_s  [0:SW];

	// D = H^2 - A*C, C carried as sign and magnitude
	assign d_c    = cn_s6 ? $signed(DSW'(hh_s6) + DSW'(ac_s6))
	                      : $signed(DSW'(hh_s6) - DSW'(ac_s6));
	assign dneg_c = d_c[DSW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s[0]   <= dneg_c ? '0 : DUW'(d_c[DMW-1:0]);
			sq_r_s[0]   <= '0;
			sq_h_s[0]   <= h_s6;
			sq_a_s[0]   <= a_s6;
			sq_hit_s[0] <= az_s6 ? cle_s6 : !dneg_c;
			sq_tz_s[0]  <= az_s6 || dneg_c;
		end
	end

	// one root bit per stage, highest first
	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		localparam logic [DUW-1:0] RBIT = DUW'(1) << (2 * (SW - 1 - k));
		logic [DUW-1:0] trial_c;

		assign trial_c = sq_r_s[k] + RBIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (sq_x_s[k] >= trial_c) begin
					sq_x_s[k+1] <= sq_x_s[k] - trial_c;
					sq_r_s[k+1] <= (sq_r_s[k] >> 1) + RBIT;
				end else begin
					sq_x_s[k+1] <= sq_x_s[k];
					sq_r_s[k+1] <= sq_r_s[k] >> 1;
				end
				sq_h_s[k+1]   <= sq_h_s[k];
				sq_a_s[k+1]   <= sq_a_s[k];
				sq_hit_s[k+1] <= sq_hit_s[k];
				sq_tz_s[k+1]  <= sq_tz_s[k];
			end
		end
	end

	// ---------------- root selection ----------------
	logic signed [TW-1:0] nh_c, s_c, t1_c, t2_c, num_c;
	logic signed [TW-1:0] num_st;
	logic [AMW-1:0]       a_st, a_sm;
	logic                 hit_st, tz_st, hit_sm, tz_sm;
	logic [TW-1:0]        nm_sm;
	logic                 nn_sm;

	assign nh_c = -TW'(sq_h_s[SW]);
	assign s_c  = $signed(TW'(sq_r_s[SW][SW-1:0]));
	assign t1_c = nh_c + s_c;
	assign t2_c = nh_c - s_c;

	always_comb begin
		priority if (!t1_c[TW-1] && !t2_c[TW-1]) begin
			num_c = t2_c;
		end else if ((t1_c[TW-1] || t1_c == '0) && (t2_c[TW-1] || t2_c == '0)) begin
			num_c = t1_c;
		end else begin
			num_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_st <= num_c;
			a_st   <= sq_a_s[SW];
			hit_st <= sq_hit_s[SW];
			tz_st  <= sq_tz_s[SW];
			nm_sm  <= num_st[TW-1] ? TW'(-num_st) : TW'(num_st);
			nn_sm  <= num_st[TW-1];
			a_sm   <= a_st;
			hit_sm <= hit_st;
			tz_sm  <= tz_st;
		end
	end

	// ---------------- divider: numerator * 2^TIME_FRAC_BITS / A ----------------
	logic [NW-1:0]  n_c, r0_c;
	logic           ovf_c;

	logic [AMW-1:0] dv_r_s   [0:QB];
	logic [QB-1:0]  dv_n_s   [0:QB];
	logic [QB-1:0]  dv_q_s   [0:QB];
	logic [AMW-1:0] dv_a_s   [0:QB];
	logic           dv_ov_s  [0:QB];
	logic           dv_ng_s  [0:QB];
	logic           dv_hit_s [0:QB];
	logic           dv_tz_s  [0:QB];

	assign n_c   = {nm_sm, {TIME_FRAC_BITS{1'b0}}};
	assign r0_c  = n_c >> QB;
	// quotient needs more than QB bits: saturate
	assign ovf_c = r0_c >= NW'(a_sm);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_r_s[0]   <= ovf_c ? '0 : AMW'(r0_c);
			dv_n_s[0]   <= n_c[QB-1:0];
			dv_q_s[0]   <= '0;
			dv_a_s[0]   <= a_sm;
			dv_ov_s[0]  <= ovf_c;
			dv_ng_s[0]  <= nn_sm;
			dv_hit_s[0] <= hit_sm;
			dv_tz_s[0]  <= tz_sm;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [AMW:0] rx_c;
		logic         ge_c;

		assign rx_c = {dv_r_s[j], dv_n_s[j][QB-1]};
		assign ge_c = rx_c >= (AMW+1)'(dv_a_s[j]);

		always_ff @(posedge clk) begin
			if (en) begin
				dv_r_s[j+1]   <= ge_c ? AMW'(rx_c - (AMW+1)'(dv_a_s[j])) : AMW'(rx_c);
				dv_n_s[j+1]   <= dv_n_s[j] << 1;
				dv_q_s[j+1]   <= {dv_q_s[j][QB-2:0], ge_c};
				dv_a_s[j+1]   <= dv_a_s[j];
				dv_ov_s[j+1]  <= dv_ov_s[j];
				dv_ng_s[j+1]  <= dv_ng_s[j];
				dv_hit_s[j+1] <= dv_hit_s[j];
				dv_tz_s[j+1]  <= dv_tz_s[j];
			end
		end
	end

	// ---------------- output stage: saturate and mask ----------------
	logic [QB-1:0]     q_c;
	logic [TW_OUT-1:0] sat_c;
	logic              hit_q;
	logic [TW_OUT-1:0] time_q;

	assign q_c = dv_q_s[QB];

	always_comb begin
		if (!dv_ng_s[QB]) begin
			if (dv_ov_s[QB] || q_c[QB-1] || q_c[TW_OUT-1]) begin
				sat_c = {1'b0, {(TW_OUT-1){1'b1}}};
			end else begin
				sat_c = q_c[TW_OUT-1:0];
			end
		end else begin
			if (dv_ov_s[QB] || q_c[QB-1] || (q_c[TW_OUT-1] && (q_c[TW_OUT-2:0] != '0))) begin
				sat_c = {1'b1, {(TW_OUT-1){1'b0}}};
			end else begin
				sat_c = -q_c[TW_OUT-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= dv_hit_s[QB];
			time_q <= (dv_hit_s[QB] && !dv_tz_s[QB]) ? sat_c : '0;
		end
	end

	assign hit      = hit_q;
	assign hit_time = $signed(time_q);

	// ---------------- checks ----------------
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_time == '0)
		else $error("miss carries a nonzero time");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready disagrees with output stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("transfer did not enter the pipe");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipe moved during a stall");

endmodule

// File: sv/mcct_mul.sv
// ----------------------------------------------------------------------------
// mcct_mul: two-stage unsigned multiplier
// Split both operands in halves, register four partial products, then sum.
// ----------------------------------------------------------------------------
module mcct_mul #(
	parameter int AW = 45,
	parameter int BW = 46
) (
	input  logic               clk,
	input  logic               en,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic [AW+BW-1:0]   p
);

	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;
	logic [PW-1:0]    p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[AL-1:0] * b[BL-1:0];
			lh_s1 <= a[AL-1:0] * b[BW-1:BL];
			hl_s1 <= a[AW-1:AL] * b[BL-1:0];
			hh_s1 <= a[AW-1:AL] * b[BW-1:BL];
			p_s2  <= (PW'(hh_s1) << (AL + BL)) + (PW'(lh_s1) << BL)
				+ (PW'(hl_s1) << AL) + PW'(ll_s1);
		end
	end

	assign p = p_s2;

endmodule
